>>> src/mcaas_pkg.sv
// mcaas_pkg: shared types, constants and the channel group table
// for the multichannel average scaler
// no dependencies
package mcaas_pkg;

    // default sizing for the top level parameters
    localparam int CHANNELS_DEF    = 12;
    localparam int DEPTH_DEF       = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // fixed field widths
    localparam int KIND_W    = 1;
    localparam int CHAN_W    = 4;
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int READING_W = 16;
    localparam int PROD_W    = SUM_W + SCALE_W;
    localparam int SCALE_SHIFT = 12;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUT_VOLTAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CURRENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_INPUT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_INPUT = 2'd3;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_READ   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
        logic                end_of_scan;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0]    channel_echo;
        logic [READING_W-1:0] reading;
    } t_out_item;

    // gain group of each channel, unused channels fall to output voltage
    function automatic logic [CFG_IDX_W-1:0] group_of_channel(input logic [CHAN_W-1:0] chan);
        logic [CFG_IDX_W-1:0] grp;
        case (chan)
            4'd2, 4'd7, 4'd8, 4'd9: grp = REG_OUT_CURRENT;
            4'd3, 4'd4:             grp = REG_WIDE_INPUT;
            4'd10, 4'd11:           grp = REG_NARROW_INPUT;
            default:                grp = REG_OUT_VOLTAGE;
        endcase
        return grp;
    endfunction

endpackage

>>> src/multichannel_adc_average_scaler.sv
// multichannel_adc_average_scaler: ring of converter scans, boxcar sum and gain per group
// depends on mcaas_pkg
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// a sample item is stored in the cycle it is accepted, the next item may follow at once
// a read item walks the DEPTH ring slots of its channel through the single memory read
// port, one slot a cycle, then the last read is summed and scaled before the result
// is loaded, and the input stalls meanwhile
// a result waiting on a stalled output holds the sequencer in its last step
// reset clears slot pointer and per-entry valid bits, presets the gains, no clearing pass
module multichannel_adc_average_scaler #(
    parameter int CHANNELS    = mcaas_pkg::CHANNELS_DEF,
    parameter int DEPTH       = mcaas_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = mcaas_pkg::SAMPLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mcaas_pkg::t_in_item          i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mcaas_pkg::t_out_item         o_out_item,
    input  logic                         i_cfg_we,
    input  logic [mcaas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcaas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mcaas_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int ADDR_W    = SLOT_W + CH_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
    localparam logic [CHAN_W:0]   CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LAST = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      r_idx;
    logic [CHAN_W-1:0]      r_chan;
    logic                   r_chan_ok;
    logic [SUM_W-1:0]       r_sum;
    logic [READING_W-1:0]   r_read;
    logic                   r_acc_en;
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_rd_ok;
    logic [SCALE_W-1:0]     r_scale [4];
    logic [MEM_DEPTH-1:0]   r_vld;
    logic [SAMPLE_BITS-1:0] r_mem [MEM_DEPTH];
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic              in_acc;
    logic              chan_in_range;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic              out_free;
    logic [PROD_W-1:0] product;
    logic [SCALE_W-1:0] scale_sel;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign chan_in_range = ({1'b0, i_in_item.channel} < CHAN_LIMIT);
    assign out_free    = !r_out_valid || !i_out_stall;

    // sample store addressing
    assign wr_en   = in_acc && (i_in_item.kind == KIND_SAMPLE) && chan_in_range;
    assign wr_addr = {r_slot, i_in_item.channel[CH_W-1:0]};
    assign rd_en   = (r_state == S_READ);
    assign rd_addr = {r_idx, r_chan[CH_W-1:0]};

    // gain of the requested channel and the one multiply
    assign scale_sel = r_scale[group_of_channel(r_chan)];
    assign product   = PROD_W'(r_sum) * PROD_W'(scale_sel);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_item.kind == KIND_READ)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_idx == LAST_SLOT) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_idx       <= '0;
            r_acc_en    <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc_en <= rd_en;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            // slot advance at scan end, sample items only
            if (in_acc && (i_in_item.kind == KIND_SAMPLE) && i_in_item.end_of_scan) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            end
            if (in_acc) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            // output register
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale[0] <= SCALE_RESET;
            r_scale[1] <= SCALE_RESET;
            r_scale[2] <= SCALE_RESET;
            r_scale[3] <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUT_VOLTAGE:  r_scale[0] <= SCALE_W'(i_cfg_data);
                REG_OUT_CURRENT:  r_scale[1] <= SCALE_W'(i_cfg_data);
                REG_WIDE_INPUT:   r_scale[2] <= SCALE_W'(i_cfg_data);
                REG_NARROW_INPUT: r_scale[3] <= SCALE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= SAMPLE_BITS'(i_in_item.sample);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_vld[rd_addr];
    end

    // datapath: latch request, accumulate, scale, load result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_chan    <= i_in_item.channel;
            r_chan_ok <= chan_in_range;
            r_sum     <= '0;
        end else if (r_acc_en) begin
            r_sum <= r_sum + (r_rd_ok ? SUM_W'(r_rd_data) : '0);
        end
        if (r_state == S_MUL) begin
            r_read <= r_chan_ok ? product[SCALE_SHIFT +: READING_W] : '0;
        end
        if (r_state == S_OUT && out_free) begin
            r_out_item.channel_echo <= r_chan;
            r_out_item.reading      <= r_read;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
